// ----- sv/bds_pkg.sv -----
// Shared types, constants and helper functions for the box downsampler.
// Used by bds_div and the top module of the box_downsample_checker_composite block.
package bds_pkg;

    // Geometry limits.
    localparam int SRC_MAX   = 4096;
    localparam int OUT_MAX   = 64;
    localparam int DIM_W     = 13;
    localparam int OUT_DIM_W = 7;
    localparam int COL_W     = 6;
    localparam int CNT_W     = 12;
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 32;
    localparam int NCH       = 4;
    localparam int ENTRY_W   = SUM_W * NCH;
    localparam int DIV_W     = 32;
    localparam int N_W       = 2 * DIM_W;
    localparam int IN_DATA_W = 32;
    localparam int OUT_DATA_W = 72;

    // Checkerboard colors and the full-scale alpha.
    localparam logic [PIX_W-1:0] BG_EVEN   = 8'hF0;
    localparam logic [PIX_W-1:0] BG_ODD    = 8'hC8;
    localparam logic [PIX_W-1:0] ALPHA_MAX = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_SRC_WIDTH  = 2'd0,
        REG_SRC_HEIGHT = 2'd1,
        REG_MAX_EDGE   = 2'd2
    } reg_idx_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_INIT,
        ST_OW,
        ST_OH,
        ST_COL,
        ST_BAND,
        ST_IDLE,
        ST_ACC,
        ST_AVG,
        ST_COMP,
        ST_EMIT,
        ST_ADV
    } state_t;

    // Divider status as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Source dimension: zero reads as one, oversize as the maximum.
    function automatic logic [DIM_W-1:0] clamp_src(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(SRC_MAX)) begin
            r = DIM_W'(SRC_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Output edge limit: zero reads as one, oversize as the maximum.
    function automatic logic [OUT_DIM_W-1:0] clamp_out(input logic [OUT_DIM_W-1:0] v);
        logic [OUT_DIM_W-1:0] r;
        if (v == '0) begin
            r = OUT_DIM_W'(1);
        end else if (v > OUT_DIM_W'(OUT_MAX)) begin
            r = OUT_DIM_W'(OUT_MAX);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- sv/bds_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; holds the column sums and the column block ends.
module bds_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 6
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/bds_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// Depends on bds_pkg for widths and the status struct.
module bds_div (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [bds_pkg::DIV_W-1:0] dividend,
    input  logic [bds_pkg::DIV_W-1:0] divisor,
    output bds_pkg::div_stat_t        stat,
    output logic [bds_pkg::DIV_W-1:0] quotient
);
    import bds_pkg::*;

    logic [DIV_W-1:0] q_reg;
    logic [DIV_W-1:0] r_reg;
    logic [DIV_W-1:0] d_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [DIV_W:0]   r_shift;
    logic [DIV_W:0]   r_diff;
    logic             ge;

    // Shift in the next dividend bit and trial-subtract.
    always_comb begin
        r_shift = {r_reg, q_reg[DIV_W-1]};
        r_diff  = r_shift - {1'b0, d_reg};
        ge      = (r_shift >= {1'b0, d_reg});
    end

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient.
    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else if (busy_reg) begin
            q_reg <= {q_reg[DIV_W-2:0], ge};
            r_reg <= ge ? r_diff[DIV_W-1:0] : r_shift[DIV_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = q_reg;

endmodule

// ----- sv/box_downsample_checker_composite_top.sv -----
// Top level of the box downsampler with checkerboard compositing.
// Depends on bds_pkg, bds_ram and bds_div.
//
// Usage: RGBA8 source pixels enter in raster order on the s_ channel, one
// transfer per pixel. When a pixel closes an output block, one result leaves
// on the m_ channel with the block position, the truncated channel averages
// and the color composited over an 8-pixel checkerboard; m_tlast marks the
// final output pixel of the image. Geometry is written through the cfg_ port
// while the block is idle; each write restarts the image.
// Sequence: a closing pixel runs four averaging divisions through the one
// shared divider, then composites the three color channels.
// A pixel that ends an output row band adds one division.
// After reset or a geometry write, setup runs up to two divisions for the
// output size, one per output column for the block ends and one for the
// first band, with s_tready low.
// The result sits in an output register, so the next pixel is taken while it
// waits; a stalled receiver holds back only the next closing pixel.
module box_downsample_checker_composite_top (
    input  logic        aclk,
    input  logic        aresetn,
    // red_in[7:0], green_in[15:8], blue_in[23:16], alpha_in[31:24]
    input  logic [31:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // out_x[5:0], out_y[11:6], avg_red[19:12], avg_green[27:20],
    // avg_blue[35:28], avg_alpha[43:36], comp_red[51:44],
    // comp_green[59:52], comp_blue[67:60], zero fill above
    output logic [71:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [12:0] cfg_wr_data
);
    import bds_pkg::*;

    state_t state_reg, state_next;

    // Configuration.
    logic [DIM_W-1:0]     sw_cfg_reg, sh_cfg_reg;
    logic [OUT_DIM_W-1:0] me_cfg_reg;
    logic [DIM_W-1:0]     sw, sh, lng;
    logic [OUT_DIM_W-1:0] me;
    logic                 cfg_hit;

    // Image geometry and position.
    logic [OUT_DIM_W-1:0] ow_reg, oh_reg;
    logic [CNT_W-1:0]     src_col_reg, src_row_reg;
    logic [COL_W-1:0]     cur_col_reg, cur_row_reg, col_idx_reg;
    logic [DIM_W-1:0]     band_start_reg, band_end_reg, col_start_reg, col_end_reg;
    logic [1:0]           ch_idx_reg;

    // Per-pixel working registers.
    logic [IN_DATA_W-1:0]          pix_reg;
    logic [OUT_MAX-1:0]            valid_reg;
    logic                          valid_rd_reg;
    logic [NCH-1:0][SUM_W-1:0]     sum_hold_reg;
    logic [N_W-1:0]                n_reg;
    logic                          emit_reg, col_close_reg;
    logic [NCH-1:0][PIX_W-1:0]     avg_reg;
    logic [NCH-2:0][PIX_W-1:0]     comp_reg;

    // Output register.
    logic                  m_tvalid_reg, m_tlast_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    // Memory ports.
    logic [ENTRY_W-1:0]    sum_rdata, sum_wdata;
    logic [NCH-1:0][SUM_W-1:0] sum_rd, sum_new;
    logic [DIM_W-1:0]      colend_rdata;
    logic                  sum_we, colend_we;

    // Divider ports.
    logic                  div_start;
    logic [DIV_W-1:0]      div_dividend, div_divisor, div_q;
    div_stat_t             div_stat;

    // Control strobes.
    logic in_xfer, out_free, out_load;
    logic col_close, row_close, emit_now;
    logic [N_W-1:0] n_calc;
    logic [PIX_W-1:0] bg, alpha;
    logic [16:0] comp_num;
    logic [16:0] comp_sum;
    logic [PIX_W-1:0] comp_q;
    logic last_col, row_end, img_end, band_change;

    // Effective geometry.
    always_comb begin
        sw  = clamp_src(sw_cfg_reg);
        sh  = clamp_src(sh_cfg_reg);
        me  = clamp_out(me_cfg_reg);
        lng = (sw > sh) ? sw : sh;
        cfg_hit = cfg_wr_en && (cfg_addr == REG_SRC_WIDTH || cfg_addr == REG_SRC_HEIGHT ||
                                cfg_addr == REG_MAX_EDGE);
    end

    // Column sums, four channels per output column.
    bds_ram #(.DATA_W(ENTRY_W), .ADDR_W(COL_W)) u_sum_ram (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (cur_col_reg),
        .wdata (sum_wdata),
        .raddr (cur_col_reg),
        .rdata (sum_rdata)
    );

    // Source column at which each output column closes.
    bds_ram #(.DATA_W(DIM_W), .ADDR_W(COL_W)) u_colend_ram (
        .aclk  (aclk),
        .we    (colend_we),
        .waddr (col_idx_reg),
        .wdata (div_q[DIM_W-1:0]),
        .raddr (cur_col_reg),
        .rdata (colend_rdata)
    );

    bds_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    // Accumulate the read-back sums; an entry not yet written since the image
    // began reads as zero.
    always_comb begin
        sum_rd = valid_rd_reg ? sum_rdata : '0;
        for (int c = 0; c < NCH; c++) begin
            sum_new[c] = sum_rd[c] + SUM_W'(pix_reg[c*PIX_W +: PIX_W]);
        end
        sum_wdata = emit_now ? '0 : sum_new;
        col_close = ({1'b0, src_col_reg} + DIM_W'(1)) >= colend_rdata;
        row_close = ({1'b0, src_row_reg} + DIM_W'(1)) >= band_end_reg;
        emit_now  = col_close && row_close;
        n_calc    = (colend_rdata - col_start_reg) * (band_end_reg - band_start_reg);
    end

    // Compositing over the checkerboard; the divide by 255 is exact for any
    // numerator up to 255 * 255 in this shift-and-add form.
    always_comb begin
        bg       = (cur_col_reg[3] ^ cur_row_reg[3]) ? BG_ODD : BG_EVEN;
        alpha    = avg_reg[NCH-1];
        comp_num = 17'(avg_reg[ch_idx_reg]) * 17'(alpha) +
                   17'(bg) * 17'(ALPHA_MAX - alpha);
        comp_sum = comp_num + 17'(1) + 17'(comp_num[16:8]);
        comp_q   = comp_sum[15:8];
    end

    // Position bookkeeping for the advance step.
    always_comb begin
        last_col    = ({1'b0, src_col_reg} + DIM_W'(1)) >= sw;
        row_end     = ({1'b0, src_row_reg} + DIM_W'(1)) >= sh;
        img_end     = last_col && row_end;
        band_change = last_col && !row_end &&
                      (({1'b0, src_row_reg} + DIM_W'(1)) >= band_end_reg);
    end

    // Divider operand selection.
    always_comb begin
        div_dividend = '0;
        div_divisor  = DIV_W'(ALPHA_MAX);
        case (state_reg)
            ST_OW: begin
                div_dividend = DIV_W'(sw) * DIV_W'(me);
                div_divisor  = DIV_W'(lng);
            end
            ST_OH: begin
                div_dividend = DIV_W'(sh) * DIV_W'(me);
                div_divisor  = DIV_W'(lng);
            end
            ST_COL: begin
                div_dividend = DIV_W'({1'b0, col_idx_reg} + OUT_DIM_W'(1)) * DIV_W'(sw);
                div_divisor  = DIV_W'(ow_reg);
            end
            ST_BAND: begin
                div_dividend = DIV_W'({1'b0, cur_row_reg} + OUT_DIM_W'(1)) * DIV_W'(sh);
                div_divisor  = DIV_W'(oh_reg);
            end
            ST_AVG: begin
                div_dividend = sum_hold_reg[ch_idx_reg];
                div_divisor  = DIV_W'(n_reg);
            end
            default: begin
                div_dividend = '0;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT: state_next = (lng > DIM_W'(me)) ? ST_OW : ST_COL;
            ST_OW:   if (div_stat.done) state_next = ST_OH;
            ST_OH:   if (div_stat.done) state_next = ST_COL;
            ST_COL: begin
                if (div_stat.done && ({1'b0, col_idx_reg} + OUT_DIM_W'(1)) == ow_reg) begin
                    state_next = ST_BAND;
                end
            end
            ST_BAND: if (div_stat.done) state_next = ST_IDLE;
            ST_IDLE: if (in_xfer) state_next = ST_ACC;
            ST_ACC:  state_next = emit_now ? ST_AVG : ST_ADV;
            ST_AVG:  if (div_stat.done && ch_idx_reg == 2'd3) state_next = ST_COMP;
            ST_COMP: if (ch_idx_reg == 2'd2) state_next = ST_EMIT;
            ST_EMIT: if (out_free) state_next = ST_ADV;
            ST_ADV:  state_next = (img_end || band_change) ? ST_BAND : ST_IDLE;
            default: state_next = ST_INIT;
        endcase
        if (cfg_hit) begin
            state_next = ST_INIT;
        end
    end

    // State-decoded strobes.
    always_comb begin
        s_tready  = (state_reg == ST_IDLE);
        in_xfer   = s_tvalid && (state_reg == ST_IDLE);
        out_free  = !m_tvalid_reg || m_tready;
        out_load  = (state_reg == ST_EMIT) && out_free;
        sum_we    = (state_reg == ST_ACC);
        colend_we = (state_reg == ST_COL) && div_stat.done;
        div_start = 1'b0;
        case (state_reg)
            ST_OW, ST_OH, ST_COL, ST_BAND, ST_AVG: begin
                div_start = !div_stat.busy && !div_stat.done;
            end
            default: div_start = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_INIT;
            sw_cfg_reg     <= DIM_W'(64);
            sh_cfg_reg     <= DIM_W'(64);
            me_cfg_reg     <= OUT_DIM_W'(64);
            ow_reg         <= OUT_DIM_W'(1);
            oh_reg         <= OUT_DIM_W'(1);
            src_col_reg    <= '0;
            src_row_reg    <= '0;
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            col_idx_reg    <= '0;
            ch_idx_reg     <= '0;
            band_start_reg <= '0;
            band_end_reg   <= '0;
            col_start_reg  <= '0;
            valid_reg      <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;

            // Output handshake.
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // Geometry writes.
            if (cfg_wr_en) begin
                case (reg_idx_t'(cfg_addr))
                    REG_SRC_WIDTH:  sw_cfg_reg <= cfg_wr_data;
                    REG_SRC_HEIGHT: sh_cfg_reg <= cfg_wr_data;
                    REG_MAX_EDGE:   me_cfg_reg <= cfg_wr_data[OUT_DIM_W-1:0];
                    default: ;
                endcase
            end

            case (state_reg)
                // Begin a new image with fresh geometry.
                ST_INIT: begin
                    ow_reg         <= sw[OUT_DIM_W-1:0];
                    oh_reg         <= sh[OUT_DIM_W-1:0];
                    src_col_reg    <= '0;
                    src_row_reg    <= '0;
                    cur_col_reg    <= '0;
                    cur_row_reg    <= '0;
                    col_idx_reg    <= '0;
                    band_start_reg <= '0;
                    col_start_reg  <= '0;
                    valid_reg      <= '0;
                end
                ST_OW: begin
                    if (div_stat.done) begin
                        ow_reg <= (div_q == '0) ? OUT_DIM_W'(1) : div_q[OUT_DIM_W-1:0];
                    end
                end
                ST_OH: begin
                    if (div_stat.done) begin
                        oh_reg <= (div_q == '0) ? OUT_DIM_W'(1) : div_q[OUT_DIM_W-1:0];
                    end
                end
                ST_COL: begin
                    if (div_stat.done) begin
                        col_idx_reg <= col_idx_reg + COL_W'(1);
                    end
                end
                ST_BAND: begin
                    if (div_stat.done) begin
                        band_end_reg <= div_q[DIM_W-1:0];
                    end
                end
                ST_ACC: begin
                    valid_reg[cur_col_reg] <= 1'b1;
                    ch_idx_reg <= '0;
                end
                ST_AVG: begin
                    if (div_stat.done) begin
                        ch_idx_reg <= ch_idx_reg + 2'd1;
                    end
                end
                ST_COMP: begin
                    ch_idx_reg <= (ch_idx_reg == 2'd2) ? 2'd0 : ch_idx_reg + 2'd1;
                end
                // Step to the next source pixel.
                ST_ADV: begin
                    if (last_col) begin
                        src_col_reg   <= '0;
                        cur_col_reg   <= '0;
                        col_start_reg <= '0;
                        if (img_end) begin
                            src_row_reg    <= '0;
                            cur_row_reg    <= '0;
                            band_start_reg <= '0;
                            valid_reg      <= '0;
                        end else begin
                            src_row_reg <= src_row_reg + CNT_W'(1);
                            if (band_change) begin
                                if (({1'b0, cur_row_reg} + OUT_DIM_W'(1)) < oh_reg) begin
                                    cur_row_reg <= cur_row_reg + COL_W'(1);
                                end
                                band_start_reg <= band_end_reg;
                            end
                        end
                    end else begin
                        src_col_reg <= src_col_reg + CNT_W'(1);
                        if (col_close_reg &&
                            ({1'b0, cur_col_reg} + OUT_DIM_W'(1)) < ow_reg) begin
                            cur_col_reg   <= cur_col_reg + COL_W'(1);
                            col_start_reg <= col_end_reg;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            pix_reg      <= s_tdata;
            valid_rd_reg <= valid_reg[cur_col_reg];
        end
        if (state_reg == ST_ACC) begin
            sum_hold_reg  <= sum_new;
            n_reg         <= (n_calc == '0) ? N_W'(1) : n_calc;
            emit_reg      <= emit_now;
            col_close_reg <= col_close;
            col_end_reg   <= colend_rdata;
        end
        if (state_reg == ST_AVG && div_stat.done) begin
            avg_reg[ch_idx_reg] <= (div_q > DIV_W'(ALPHA_MAX)) ? ALPHA_MAX
                                                                : div_q[PIX_W-1:0];
        end
        if (state_reg == ST_COMP) begin
            comp_reg[ch_idx_reg] <= comp_q;
        end
        if (out_load) begin
            m_tdata_reg <= {4'b0, comp_reg[2], comp_reg[1], comp_reg[0],
                            avg_reg[3], avg_reg[2], avg_reg[1], avg_reg[0],
                            cur_row_reg, cur_col_reg};
            m_tlast_reg <= (({1'b0, cur_col_reg} + OUT_DIM_W'(1)) == ow_reg) &&
                           (({1'b0, cur_row_reg} + OUT_DIM_W'(1)) == oh_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // The divider is only ever busy while no pixel can be taken.
    a_div_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> !s_tready)
        else $error("input ready while divider busy");

    // A geometry write stops input until setup has run.
    a_cfg_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_hit |=> !s_tready)
        else $error("input ready right after geometry write");

    // The current output column stays inside the output width.
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> ({1'b0, cur_col_reg} < ow_reg))
        else $error("output column beyond output width");

    // Only a pixel that closed a block reaches the output stage.
    a_emit_only_closing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> emit_reg)
        else $error("emit without a closed block");

endmodule
